// ===== rtl/cfl_pkg.sv =====
`timescale 1ns / 1ps
package cfl_pkg;

    localparam int POSITION_BITS_DEF = 16;
    localparam int FIFO_DEPTH        = 4;
    localparam int FIELD_POS_BITS    = 16;

    typedef enum logic [4:0] {
        MODE_IDLE    = 5'b00001,
        MODE_NUMBER  = 5'b00010,
        MODE_WORD    = 5'b00100,
        MODE_STRING  = 5'b01000,
        MODE_COMMENT = 5'b10000
    } t_mode;

    localparam logic [1:0] EV_BYTE     = 2'd0;
    localparam logic [1:0] EV_COMPLETE = 2'd1;
    localparam logic [1:0] EV_ERROR    = 2'd2;

    localparam logic [2:0] K_LBRACE = 3'd0;
    localparam logic [2:0] K_RBRACE = 3'd1;
    localparam logic [2:0] K_SEMI   = 3'd2;
    localparam logic [2:0] K_COMMA  = 3'd3;
    localparam logic [2:0] K_STRING = 3'd4;
    localparam logic [2:0] K_NUMBER = 3'd5;
    localparam logic [2:0] K_WORD   = 3'd6;
    localparam logic [2:0] K_END    = 3'd7;

    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_input;
    } t_in_req;

    typedef struct packed {
        logic [1:0]  event_res;
        logic [2:0]  kind;
        logic [7:0]  value_byte;
        logic [15:0] token_line;
        logic [15:0] token_column;
        logic        last;
    } t_out_req;

    typedef struct packed {
        logic [1:0] cnt;
        t_out_req   d0;
        t_out_req   d1;
    } t_push;

    function automatic logic is_space(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT ||
               c == CH_FF || c == CH_CR;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic logic is_single(input logic [7:0] c);
        return c == CH_LBRACE || c == CH_RBRACE || c == CH_SEMI || c == CH_COMMA;
    endfunction

    function automatic logic is_word_byte(input logic [7:0] c);
        return !(is_space(c) || is_single(c) || c == CH_HASH);
    endfunction

    function automatic logic [2:0] single_kind(input logic [7:0] c);
        logic [2:0] k;
        case (c)
            CH_LBRACE: k = K_LBRACE;
            CH_RBRACE: k = K_RBRACE;
            CH_SEMI:   k = K_SEMI;
            default:   k = K_COMMA;
        endcase
        return k;
    endfunction

endpackage

// ===== rtl/cfl_core.sv =====
`timescale 1ns / 1ps
module cfl_core #(
    parameter int POSITION_BITS = cfl_pkg::POSITION_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  cfl_pkg::t_in_req i_in_req,
    input  logic             i_room,
    output cfl_pkg::t_push   o_push
);

    localparam int PB = POSITION_BITS;

    logic             r_vld;
    cfl_pkg::t_in_req r_in;
    cfl_pkg::t_mode   r_mode, n_mode;
    logic             r_q, n_q;
    logic             r_halt, n_halt;
    logic [PB-1:0]    r_line, n_line, r_col, n_col, r_sl, n_sl, r_sc, n_sc;

    cfl_pkg::t_mode    i_mode;
    logic              i_q, i_has;
    logic [PB-1:0]     i_line, i_col, i_sl, i_sc;
    cfl_pkg::t_out_req i_res, res0, res1;
    logic [1:0]        cnt;
    logic [7:0]        c;
    logic              fire;

    function automatic logic [PB-1:0] sat_inc(input logic [PB-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic cfl_pkg::t_out_req mk(input logic [1:0] ev, input logic [2:0] k,
                                             input logic [7:0] val,
                                             input logic [PB-1:0] ln,
                                             input logic [PB-1:0] cl);
        cfl_pkg::t_out_req r;
        r.event_res    = ev;
        r.kind         = k;
        r.value_byte   = val;
        r.token_line   = 16'(ln);
        r.token_column = 16'(cl);
        r.last         = 1'b0;
        return r;
    endfunction

    assign c          = r_in.char_byte;
    assign fire       = r_vld && i_room;
    assign o_in_ready = !r_vld || fire;

    // byte handling from idle
    always_comb begin
        i_mode = cfl_pkg::MODE_IDLE;
        i_q    = r_q;
        i_line = r_line;
        i_col  = r_col;
        i_sl   = r_sl;
        i_sc   = r_sc;
        i_has  = 1'b0;
        i_res  = '0;
        if (cfl_pkg::is_space(c)) begin
            if (c == cfl_pkg::CH_LF) begin
                i_line = sat_inc(r_line);
                i_col  = PB'(1);
            end else begin
                i_col = sat_inc(r_col);
            end
        end else if (c == cfl_pkg::CH_HASH) begin
            i_mode = cfl_pkg::MODE_COMMENT;
        end else if (cfl_pkg::is_single(c)) begin
            i_has = 1'b1;
            i_res = mk(cfl_pkg::EV_COMPLETE, cfl_pkg::single_kind(c), c, r_line, r_col);
            i_col = sat_inc(r_col);
        end else begin
            i_sl = r_line;
            i_sc = r_col;
            if (c == cfl_pkg::CH_DQUOTE || c == cfl_pkg::CH_SQUOTE) begin
                i_mode = cfl_pkg::MODE_STRING;
                i_q    = (c == cfl_pkg::CH_SQUOTE);
            end else begin
                i_mode = cfl_pkg::is_digit(c) ? cfl_pkg::MODE_NUMBER : cfl_pkg::MODE_WORD;
                i_has  = 1'b1;
                i_res  = mk(cfl_pkg::EV_BYTE,
                            cfl_pkg::is_digit(c) ? cfl_pkg::K_NUMBER : cfl_pkg::K_WORD,
                            c, r_line, r_col);
                i_col  = sat_inc(r_col);
            end
        end
    end

    always_comb begin
        logic [2:0] k;
        logic       cont;
        n_mode = r_mode;
        n_q    = r_q;
        n_halt = r_halt;
        n_line = r_line;
        n_col  = r_col;
        n_sl   = r_sl;
        n_sc   = r_sc;
        res0   = '0;
        res1   = '0;
        cnt    = 2'd0;
        k      = (r_mode == cfl_pkg::MODE_NUMBER) ? cfl_pkg::K_NUMBER : cfl_pkg::K_WORD;
        cont   = (r_mode == cfl_pkg::MODE_NUMBER) ? cfl_pkg::is_digit(c)
                                                  : cfl_pkg::is_word_byte(c);
        if (r_halt) begin
            cnt = 2'd0;
        end else if (r_in.end_of_input) begin
            n_mode = cfl_pkg::MODE_IDLE;
            n_halt = 1'b1;
            if (r_mode == cfl_pkg::MODE_STRING) begin
                res0 = mk(cfl_pkg::EV_ERROR, cfl_pkg::K_STRING, 8'h00, r_sl, r_sc);
                cnt  = 2'd1;
            end else if (r_mode == cfl_pkg::MODE_NUMBER || r_mode == cfl_pkg::MODE_WORD) begin
                res0 = mk(cfl_pkg::EV_COMPLETE, k, 8'h00, r_sl, r_sc);
                res1 = mk(cfl_pkg::EV_COMPLETE, cfl_pkg::K_END, 8'h00, r_line, r_col);
                cnt  = 2'd2;
            end else begin
                res0 = mk(cfl_pkg::EV_COMPLETE, cfl_pkg::K_END, 8'h00, r_line, r_col);
                cnt  = 2'd1;
            end
        end else begin
            case (r_mode)
                cfl_pkg::MODE_COMMENT: begin
                    if (c == cfl_pkg::CH_LF) begin
                        n_mode = i_mode;
                        n_line = i_line;
                        n_col  = i_col;
                    end
                end
                cfl_pkg::MODE_STRING: begin
                    if (c == (r_q ? cfl_pkg::CH_SQUOTE : cfl_pkg::CH_DQUOTE)) begin
                        res0   = mk(cfl_pkg::EV_COMPLETE, cfl_pkg::K_STRING, 8'h00, r_sl, r_sc);
                        n_mode = cfl_pkg::MODE_IDLE;
                    end else begin
                        res0  = mk(cfl_pkg::EV_BYTE, cfl_pkg::K_STRING, c, r_sl, r_sc);
                        n_col = sat_inc(r_col);
                    end
                    cnt = 2'd1;
                end
                cfl_pkg::MODE_NUMBER, cfl_pkg::MODE_WORD: begin
                    if (cont) begin
                        res0  = mk(cfl_pkg::EV_BYTE, k, c, r_sl, r_sc);
                        n_col = sat_inc(r_col);
                        cnt   = 2'd1;
                    end else begin
                        res0   = mk(cfl_pkg::EV_COMPLETE, k, 8'h00, r_sl, r_sc);
                        res1   = i_res;
                        cnt    = i_has ? 2'd2 : 2'd1;
                        n_mode = i_mode;
                        n_q    = i_q;
                        n_line = i_line;
                        n_col  = i_col;
                        n_sl   = i_sl;
                        n_sc   = i_sc;
                    end
                end
                default: begin
                    res0   = i_res;
                    cnt    = i_has ? 2'd1 : 2'd0;
                    n_mode = i_mode;
                    n_q    = i_q;
                    n_line = i_line;
                    n_col  = i_col;
                    n_sl   = i_sl;
                    n_sc   = i_sc;
                end
            endcase
        end
        if (cnt == 2'd1) begin
            res0.last = 1'b1;
        end
        if (cnt == 2'd2) begin
            res1.last = 1'b1;
        end
    end

    assign o_push.cnt = fire ? cnt : 2'd0;
    assign o_push.d0  = res0;
    assign o_push.d1  = res1;

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= 1'b0;
            r_mode <= cfl_pkg::MODE_IDLE;
            r_q    <= 1'b0;
            r_halt <= 1'b0;
            r_line <= PB'(1);
            r_col  <= PB'(1);
            r_sl   <= PB'(1);
            r_sc   <= PB'(1);
        end else begin
            if (o_in_ready) begin
                r_vld <= i_in_valid;
            end
            if (fire) begin
                r_mode <= n_mode;
                r_q    <= n_q;
                r_halt <= n_halt;
                r_line <= n_line;
                r_col  <= n_col;
                r_sl   <= n_sl;
                r_sc   <= n_sc;
            end
        end
    end

endmodule

// ===== rtl/cfl_fifo.sv =====
`timescale 1ns / 1ps
module cfl_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cfl_pkg::t_push    i_push,
    output logic              o_room,
    output logic              o_valid,
    input  logic              i_ready,
    output cfl_pkg::t_out_req o_data
);

    localparam int DEPTH = cfl_pkg::FIFO_DEPTH;
    localparam int AW    = $clog2(DEPTH);

    cfl_pkg::t_out_req r_mem [DEPTH];
    logic [AW-1:0]     r_wr, r_rd;
    logic [AW:0]       r_count, n_count;
    logic              pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign pop     = o_valid && i_ready;
    assign o_room  = (r_count <= (AW+1)'(DEPTH - 2));
    assign n_count = r_count + (AW+1)'(i_push.cnt) - (AW+1)'(pop);

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr] <= i_push.d0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[AW'(r_wr + 1'b1)] <= i_push.d1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= AW'(r_wr + AW'(i_push.cnt));
            r_count <= n_count;
            if (pop) begin
                r_rd <= AW'(r_rd + 1'b1);
            end
        end
    end

endmodule

// ===== rtl/config_file_lexer.sv =====
`timescale 1ns / 1ps
// Streaming lexer for configuration text.
// Input channel: one request per text byte (char_byte), or an end mark
// (end_of_input) that flushes a pending token and produces the end token,
// or the error for an open string. Output channel: zero, one or two result
// requests per input request: value bytes, token completions with start
// line/column, or an unterminated-string error. The final result of each input carries last.
// Path from accepting an input to the earliest accept of its first result:
// input register, then result queue.
// Throughput: one input per cycle while the result queue has room; an input
// that yields two results writes both at once into the 4-entry result
// queue. The queue accepts a new input only with two free entries.
// Reset (synchronous, active low) empties the input register and result
// queue, sets line and column to 1 and clears the halt flag.
// After the end token or the error, inputs are taken and dropped.
// When the receiver stalls, results wait in the queue, the input register
// fills, then o_in_ready falls until space frees.
module config_file_lexer #(
    parameter int POSITION_BITS = cfl_pkg::POSITION_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  cfl_pkg::t_in_req  i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output cfl_pkg::t_out_req o_out_req
);

    cfl_pkg::t_push push;
    logic           room;

    cfl_core #(
        .POSITION_BITS(POSITION_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_req   (i_in_req),
        .i_room     (room),
        .o_push     (push)
    );

    cfl_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_req)
    );

endmodule

// ===== rtl/cfl_checker.sv =====
`timescale 1ns / 1ps
module cfl_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input cfl_pkg::t_out_req i_out_req
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_req))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_req.event_res == cfl_pkg::EV_ERROR |->
            i_out_req.last && i_out_req.kind == cfl_pkg::K_STRING)
        else $error("error result malformed");

    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_req.kind == cfl_pkg::K_END |->
            i_out_req.last && i_out_req.event_res == cfl_pkg::EV_COMPLETE)
        else $error("end token malformed");

endmodule

bind config_file_lexer cfl_checker u_cfl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_req   (o_out_req)
);
